>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
	else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
	else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

>>> hw/rtl/aabb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package aabb_pkg;
	localparam int NumBodies = 8;
	localparam int EdgeCount = 2 * NumBodies;
	localparam int BodyW = 3;
	localparam int EdgeW = $clog2(EdgeCount);
	localparam int PassW = $clog2(EdgeCount + 1);
	localparam int NumAxes = 3;

	typedef logic [EdgeW-1:0] edge_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SORT,
		ST_RANK,
		ST_TEST
	} state_t;

	typedef struct packed {
		logic       load;
		logic       pass_odd;
		logic       sort_en;
	} lane_ctl_t;

	typedef struct packed {
		logic [BodyW-1:0] first_body;
		logic [BodyW-1:0] second_body;
		logic             boxes_overlap;
		logic             final_pair;
	} pair_t;

	typedef struct packed {
		logic [BodyW-1:0] body_index;
		logic [31:0]      x_low;
		logic [31:0]      x_high;
		logic [31:0]      y_low;
		logic [31:0]      y_high;
		logic [31:0]      z_low;
		logic [31:0]      z_high;
		logic             frame_end;
	} box_t;
endpackage
`default_nettype wire

>>> hw/rtl/aabb_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface aabb_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/aabb_axis_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// One axis: bound registers, persistent edge list, one transposition pass a cycle while sort_en is set.
module aabb_axis_lane (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire aabb_pkg::lane_ctl_t ctl,
	input  wire logic [aabb_pkg::BodyW-1:0] load_body,
	input  wire logic [31:0]         load_low,
	input  wire logic [31:0]         load_high,
	output logic [aabb_pkg::NumBodies-1:0][aabb_pkg::EdgeW-1:0] start_rank,
	output logic [aabb_pkg::NumBodies-1:0][aabb_pkg::EdgeW-1:0] end_rank
);
	localparam int E = aabb_pkg::EdgeCount;

	logic [31:0] bound_q [E];
	aabb_pkg::edge_t order_q [E];
	aabb_pkg::edge_t order_d [E];
	logic [31:0] key [E];

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			bound_q[{load_body, 1'b0}] <= load_low;
			bound_q[{load_body, 1'b1}] <= load_high;
		end
	end

	always_comb begin
		for (int i = 0; i < E; i++) begin
			key[i] = bound_q[order_q[i]] ^ 32'h8000_0000;
		end
		order_d = order_q;
		for (int i = 0; i + 1 < E; i++) begin
			if ((i[0] == ctl.pass_odd) && (key[i] > key[i+1])) begin
				order_d[i]   = order_q[i+1];
				order_d[i+1] = order_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < E; i++) order_q[i] <= aabb_pkg::edge_t'(i);
		end else if (ctl.sort_en) begin
			order_q <= order_d;
		end
	end

	// rank registers, refreshed every cycle from the edge list
	always_ff @(posedge clk) begin
		for (int i = 0; i < E; i++) begin
			if (order_q[i][0]) end_rank[order_q[i][aabb_pkg::EdgeW-1:1]] <=
				aabb_pkg::EdgeW'(i);
			else start_rank[order_q[i][aabb_pkg::EdgeW-1:1]] <= aabb_pkg::EdgeW'(i);
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/aabb_pair_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// Combine the three lanes' ranks into one pair verdict.
module aabb_pair_merge (
	input  wire logic [aabb_pkg::NumAxes-1:0][aabb_pkg::NumBodies-1:0][aabb_pkg::EdgeW-1:0] sr,
	input  wire logic [aabb_pkg::NumAxes-1:0][aabb_pkg::NumBodies-1:0][aabb_pkg::EdgeW-1:0] er,
	input  wire logic [aabb_pkg::BodyW-1:0] a,
	input  wire logic [aabb_pkg::BodyW-1:0] b,
	output logic hit
);
	always_comb begin
		hit = 1'b1;
		for (int x = 0; x < aabb_pkg::NumAxes; x++) begin
			if (!((sr[x][a] < sr[x][b] && sr[x][b] < er[x][a]) ||
			      (sr[x][b] < sr[x][a] && sr[x][a] < er[x][b]))) hit = 1'b0;
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/aabb_sweep_prune_broad_phase_top.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   | dir | payload
// box_in    | in  | body_index, x/y/z low/high (signed Q16.16), frame_end
// pair_out  | out | first_body, second_body, boxes_overlap, final_pair
// Each box, frame_end or not, loads its bounds. A frame end then runs 2N sort
// passes (one a cycle, all three axis lanes together), a rank step, and
// 28 pair results, one per cycle while pair_out is ready.
// Reset restores the edge lists; bounds are undefined until loaded.
// A stalled pair_out holds the pair counter; box_in is held off until done.
`include "assert_macros.svh"
module aabb_sweep_prune_broad_phase_top (
	input wire logic clk,
	input wire logic arst_n,
	aabb_stream_if.sink   box_in,
	aabb_stream_if.source pair_out
);
	localparam int N = aabb_pkg::NumBodies;
	localparam int BW = aabb_pkg::BodyW;

	aabb_pkg::state_t state_q, state_d;
	logic [aabb_pkg::PassW-1:0] pass_q;
	logic [BW-1:0] a_q, b_q;
	aabb_pkg::lane_ctl_t ctl;
	aabb_pkg::box_t bx;
	logic [aabb_pkg::NumAxes-1:0][N-1:0][aabb_pkg::EdgeW-1:0] sr, er;
	logic hit, last_pair, in_fire, out_fire;

	assign bx = box_in.data;
	assign in_fire = box_in.valid && box_in.ready;
	assign out_fire = pair_out.valid && pair_out.ready;
	assign last_pair = (a_q == BW'(N - 2)) && (b_q == BW'(N - 1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			aabb_pkg::ST_LOAD: if (in_fire && bx.frame_end) state_d = aabb_pkg::ST_SORT;
			aabb_pkg::ST_SORT:
				if (pass_q == aabb_pkg::PassW'(aabb_pkg::EdgeCount - 1))
					state_d = aabb_pkg::ST_RANK;
			aabb_pkg::ST_RANK: state_d = aabb_pkg::ST_TEST;
			aabb_pkg::ST_TEST: if (out_fire && last_pair) state_d = aabb_pkg::ST_LOAD;
			default: state_d = aabb_pkg::ST_LOAD;
		endcase
	end

	// outputs
	always_comb begin
		box_in.ready = (state_q == aabb_pkg::ST_LOAD);
		pair_out.valid = (state_q == aabb_pkg::ST_TEST);
		ctl.load = in_fire && ({{(32-BW){1'b0}}, bx.body_index} < 32'(N));
		ctl.sort_en = (state_q == aabb_pkg::ST_SORT);
		ctl.pass_odd = pass_q[0];
		pair_out.data.first_body = a_q;
		pair_out.data.second_body = b_q;
		pair_out.data.boxes_overlap = hit;
		pair_out.data.final_pair = last_pair;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aabb_pkg::ST_LOAD;
			pass_q <= '0;
			a_q <= '0;
			b_q <= BW'(1);
		end else begin
			state_q <= state_d;
			// advance sort pass count
			if (state_q == aabb_pkg::ST_SORT) pass_q <= pass_q + 1'b1;
			else pass_q <= '0;
			if (state_q == aabb_pkg::ST_RANK) begin
				a_q <= '0;
				b_q <= BW'(1);
			end else if (out_fire) begin
				// walk pairs in order (0,1),(0,2),...
				if (b_q == BW'(N - 1)) begin
					a_q <= a_q + 1'b1;
					b_q <= a_q + BW'(2);
				end else begin
					b_q <= b_q + 1'b1;
				end
			end
		end
	end

	aabb_axis_lane u_x (.clk, .arst_n, .ctl, .load_body(bx.body_index),
		.load_low(bx.x_low), .load_high(bx.x_high), .start_rank(sr[0]), .end_rank(er[0]));
	aabb_axis_lane u_y (.clk, .arst_n, .ctl, .load_body(bx.body_index),
		.load_low(bx.y_low), .load_high(bx.y_high), .start_rank(sr[1]), .end_rank(er[1]));
	aabb_axis_lane u_z (.clk, .arst_n, .ctl, .load_body(bx.body_index),
		.load_low(bx.z_low), .load_high(bx.z_high), .start_rank(sr[2]), .end_rank(er[2]));

	aabb_pair_merge u_merge (.sr, .er, .a(a_q), .b(b_q), .hit);

	`ASSERT_IMPLIES(a_order, clk, arst_n, pair_out.valid, a_q < b_q)
	`ASSERT_IMPLIES(a_noin, clk, arst_n, pair_out.valid, !box_in.ready)
	`ASSERT_NEXT(a_done, clk, arst_n, out_fire && last_pair, box_in.ready)
endmodule
`default_nettype wire
